// File: hdl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants of the region profile counter table: item and
// result beats, opcodes, status codes and the stored entry layout.
// ----------------------------------------------------------------------------
package rpc_pkg;

	localparam int unsigned REGION_W = 6;
	localparam int unsigned DEPTH_W  = 8;
	localparam int unsigned TIME_W   = 40;
	localparam int unsigned SUM_W    = 48;
	localparam int unsigned CNT_W    = 32;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_END   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} rpc_op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERFLOW = 3'd1,
		ST_UNKNOWN  = 3'd2,
		ST_NO_START = 3'd3,
		ST_DISABLED = 3'd4,
		ST_NEG_WALL = 3'd5
	} rpc_status_t;

	typedef struct packed {
		logic [1:0]          op;
		logic [REGION_W-1:0] region;
		logic [DEPTH_W-1:0]  max_nesting;
		logic [TIME_W-1:0]   wall_time;
		logic [TIME_W-1:0]   user_time;
		logic [TIME_W-1:0]   system_time;
	} rpc_item_t;

	typedef struct packed {
		logic [2:0]               status;
		logic [DEPTH_W-1:0]       depth;
		logic [CNT_W-1:0]         occurrences;
		logic signed [SUM_W-1:0]  wall_total;
		logic signed [SUM_W-1:0]  user_total;
		logic signed [SUM_W-1:0]  system_total;
	} rpc_result_t;

	// base = total minus the timestamp latched at the outermost start, so that
	// closing the outermost level is a single add of the current timestamp
	typedef struct packed {
		logic               valid;
		logic [DEPTH_W-1:0] depth;
		logic [TIME_W-1:0]  wall_mark;
		logic [SUM_W-1:0]   wall_base;
		logic [SUM_W-1:0]   user_base;
		logic [SUM_W-1:0]   system_base;
		logic [SUM_W-1:0]   wall_sum;
		logic [SUM_W-1:0]   user_sum;
		logic [SUM_W-1:0]   system_sum;
		logic [CNT_W-1:0]   count;
	} rpc_entry_t;

endpackage

// File: hdl/region_profile_counter_table.sv
// ----------------------------------------------------------------------------
// region_profile_counter_table
// Per-region profiling counters: nesting depth, completed count and wrapping
// wall, user and system totals, updated by start, end, clear and read beats.
// ----------------------------------------------------------------------------
// Usage: after reset, busy stays high while the entry memory is swept
// invalid; after that busy is low for good and a beat may be issued with
// start on every cycle. Each beat gets exactly one result, shown with done
// for one cycle, once stage 1 has read the entry memory and stage 2 has
// computed the entry, written it back and registered the result. There is
// no backpressure on the result side: the receiver must take done when it
// comes. Throughput is one beat per cycle, set by the single read-modify-write
// of the entry memory per cycle; a bypass register covers a beat that hits
// the region written on the edge its read was issued. The enable register is
// written with cfg_we and is meant to change only while no beat is in flight.
// ----------------------------------------------------------------------------
module region_profile_counter_table #(
	parameter int unsigned REGIONS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  rpc_pkg::rpc_item_t   item,
	output logic                 done,
	output rpc_pkg::rpc_result_t result,
	input  logic                 cfg_we,
	input  logic                 cfg_data
);

	localparam int unsigned IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;

	// configuration
	logic enable_q;

	// reset sweep
	logic             sweep_q;
	logic [IDX_W-1:0] sweep_idx_q;
	logic             sweep_last;

	// stage 1: beat waiting on its entry read
	logic               v_s1;
	rpc_pkg::rpc_item_t item_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               in_range_s1;

	// bypass of the most recent memory write
	logic                fwd_v_q;
	logic [IDX_W-1:0]    fwd_idx_q;
	rpc_pkg::rpc_entry_t fwd_entry_q;

	// memory ports
	logic                accept;
	logic [IDX_W-1:0]    rd_idx;
	rpc_pkg::rpc_entry_t rd_entry;
	rpc_pkg::rpc_entry_t cur_entry;
	rpc_pkg::rpc_entry_t nxt_entry;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	rpc_pkg::rpc_entry_t wr_entry;

	// stage 2: result register
	logic                 done_q;
	rpc_pkg::rpc_result_t result_q;
	rpc_pkg::rpc_result_t result_d;

	assign busy   = sweep_q;
	assign accept = start && !busy;
	assign rd_idx = IDX_W'(item.region);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			enable_q <= cfg_data;
		end
	end

	// invalidate every entry once after reset, one per cycle
	assign sweep_last = (sweep_idx_q == IDX_W'(REGIONS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b1;
			sweep_idx_q <= '0;
		end else if (sweep_q) begin
			sweep_idx_q <= sweep_idx_q + IDX_W'(1);
			if (sweep_last) begin
				sweep_q <= 1'b0;
			end
		end
	end

	// stage 1 capture, entry read issued on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= item;
			idx_s1      <= rd_idx;
			in_range_s1 <= (32'(item.region) < 32'(REGIONS));
		end
	end

	rpc_entry_ram #(
		.DEPTH (REGIONS),
		.IDX_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_entry),
		.raddr (rd_idx),
		.rdata (rd_entry)
	);

	// the read missed the write on its own edge; the bypass holds the latest
	// write, which is also correct when it is older
	assign cur_entry = (fwd_v_q && (fwd_idx_q == idx_s1)) ? fwd_entry_q : rd_entry;

	rpc_update u_update (
		.item     (item_s1),
		.enable   (enable_q),
		.in_range (in_range_s1),
		.cur      (cur_entry),
		.nxt      (nxt_entry),
		.result   (result_d)
	);

	// write back every in-range beat, the sweep has the port while it runs
	assign wr_en    = sweep_q || (v_s1 && in_range_s1);
	assign wr_idx   = sweep_q ? sweep_idx_q : idx_s1;
	assign wr_entry = sweep_q ? '0 : nxt_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (wr_en) begin
			fwd_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_idx_q   <= wr_idx;
			fwd_entry_q <= wr_entry;
		end
	end

	// result beat, one cycle only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// no result while the sweep runs
	a_no_done_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result beat during reset sweep");

	// every accepted beat is answered with done after stage 1 and the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted beat did not produce a result");

	// a result without a known entry carries zero fields
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == rpc_pkg::ST_UNKNOWN)) |->
		((result.depth == '0) && (result.occurrences == '0) &&
		(result.wall_total == '0)))
		else $error("unknown region result with nonzero fields");

	// end without start reports depth zero
	a_no_start_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == rpc_pkg::ST_NO_START)) |-> (result.depth == '0))
		else $error("end without start reported nonzero depth");

endmodule

// File: hdl/rpc_entry_ram.sv
// ----------------------------------------------------------------------------
// rpc_entry_ram
// One write port, one read port entry memory with registered read data.
// ----------------------------------------------------------------------------
module rpc_entry_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IDX_W = 6
) (
	input  logic                clk,
	input  logic                we,
	input  logic [IDX_W-1:0]    waddr,
	input  rpc_pkg::rpc_entry_t wdata,
	input  logic [IDX_W-1:0]    raddr,
	output rpc_pkg::rpc_entry_t rdata
);

	rpc_pkg::rpc_entry_t mem [DEPTH];
	rpc_pkg::rpc_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/rpc_update.sv
// ----------------------------------------------------------------------------
// rpc_update
// Next entry and result for one beat, given the current entry of its region.
// ----------------------------------------------------------------------------
module rpc_update (
	input  rpc_pkg::rpc_item_t   item,
	input  logic                 enable,
	input  logic                 in_range,
	input  rpc_pkg::rpc_entry_t  cur,
	output rpc_pkg::rpc_entry_t  nxt,
	output rpc_pkg::rpc_result_t result
);

	logic [rpc_pkg::SUM_W-1:0] wall_now;
	logic [rpc_pkg::SUM_W-1:0] user_now;
	logic [rpc_pkg::SUM_W-1:0] system_now;
	logic [rpc_pkg::SUM_W-1:0] wall_src;
	logic [rpc_pkg::SUM_W-1:0] user_src;
	logic [rpc_pkg::SUM_W-1:0] system_src;
	logic [rpc_pkg::SUM_W-1:0] wall_base_new;
	logic [rpc_pkg::SUM_W-1:0] user_base_new;
	logic [rpc_pkg::SUM_W-1:0] system_base_new;
	logic [rpc_pkg::SUM_W-1:0] wall_sum_new;
	logic [rpc_pkg::SUM_W-1:0] user_sum_new;
	logic [rpc_pkg::SUM_W-1:0] system_sum_new;
	logic                      wall_neg;
	logic [2:0]                status;

	assign wall_now   = rpc_pkg::SUM_W'(item.wall_time);
	assign user_now   = rpc_pkg::SUM_W'(item.user_time);
	assign system_now = rpc_pkg::SUM_W'(item.system_time);

	// a first start begins from zero totals
	assign wall_src   = cur.valid ? cur.wall_sum : '0;
	assign user_src   = cur.valid ? cur.user_sum : '0;
	assign system_src = cur.valid ? cur.system_sum : '0;

	assign wall_base_new   = wall_src - wall_now;
	assign user_base_new   = user_src - user_now;
	assign system_base_new = system_src - system_now;

	assign wall_sum_new   = cur.wall_base + wall_now;
	assign user_sum_new   = cur.user_base + user_now;
	assign system_sum_new = cur.system_base + system_now;

	assign wall_neg = item.wall_time < cur.wall_mark;

	always_comb begin
		nxt    = cur;
		status = rpc_pkg::ST_OK;
		unique case (item.op)
			rpc_pkg::OP_START: begin
				if (!enable) begin
					status = rpc_pkg::ST_DISABLED;
				end else if (!cur.valid) begin
					nxt.valid       = 1'b1;
					nxt.depth       = rpc_pkg::DEPTH_W'(1);
					nxt.wall_mark   = item.wall_time;
					nxt.wall_base   = wall_base_new;
					nxt.user_base   = user_base_new;
					nxt.system_base = system_base_new;
					nxt.wall_sum    = '0;
					nxt.user_sum    = '0;
					nxt.system_sum  = '0;
					nxt.count       = '0;
				end else if (cur.depth >= item.max_nesting) begin
					status = rpc_pkg::ST_OVERFLOW;
				end else begin
					if (cur.depth == '0) begin
						nxt.wall_mark   = item.wall_time;
						nxt.wall_base   = wall_base_new;
						nxt.user_base   = user_base_new;
						nxt.system_base = system_base_new;
					end
					nxt.depth = cur.depth + rpc_pkg::DEPTH_W'(1);
				end
			end
			rpc_pkg::OP_END: begin
				if (!enable) begin
					status = rpc_pkg::ST_DISABLED;
				end else if (!cur.valid) begin
					status = rpc_pkg::ST_UNKNOWN;
				end else if (cur.depth == '0) begin
					status = rpc_pkg::ST_NO_START;
				end else begin
					nxt.depth = cur.depth - rpc_pkg::DEPTH_W'(1);
					nxt.count = cur.count + rpc_pkg::CNT_W'(1);
					// closing the outermost level
					if (cur.depth == rpc_pkg::DEPTH_W'(1)) begin
						nxt.wall_sum   = wall_sum_new;
						nxt.user_sum   = user_sum_new;
						nxt.system_sum = system_sum_new;
						if (wall_neg) begin
							status = rpc_pkg::ST_NEG_WALL;
						end
					end
				end
			end
			rpc_pkg::OP_CLEAR: begin
				nxt       = '0;
				nxt.valid = 1'b1;
			end
			rpc_pkg::OP_READ: begin
				if (!cur.valid) begin
					status = rpc_pkg::ST_UNKNOWN;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_comb begin
		result = '0;
		if (!in_range) begin
			result.status = rpc_pkg::ST_UNKNOWN;
		end else begin
			result.status = status;
			if (nxt.valid) begin
				result.depth        = nxt.depth;
				result.occurrences  = nxt.count;
				result.wall_total   = nxt.wall_sum;
				result.user_total   = nxt.user_sum;
				result.system_total = nxt.system_sum;
			end
		end
	end

endmodule

// File: test/rpc_checker.sv
// ----------------------------------------------------------------------------
// rpc_checker
// Watches the beat, result and enable ports of the region profile counter
// table. It keeps its own copy of every region entry and works out the
// result of each accepted beat, then compares the results in order.
// ----------------------------------------------------------------------------
module rpc_checker
	import rpc_pkg::*;
#(
	parameter int unsigned REGIONS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  rpc_item_t   item,
	input  logic        done,
	input  rpc_result_t result,
	input  logic        cfg_we,
	input  logic        cfg_data,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// mirrored region table
	logic               region_live  [REGIONS];
	logic [DEPTH_W-1:0] region_depth [REGIONS];
	logic [TIME_W-1:0]  wall_start   [REGIONS];
	logic [TIME_W-1:0]  user_start   [REGIONS];
	logic [TIME_W-1:0]  sys_start    [REGIONS];
	logic [SUM_W-1:0]   wall_acc     [REGIONS];
	logic [SUM_W-1:0]   user_acc     [REGIONS];
	logic [SUM_W-1:0]   sys_acc      [REGIONS];
	logic [CNT_W-1:0]   close_count  [REGIONS];
	logic               enable_q;

	rpc_result_t pending_results [$];
	int          fail_count;

	// next state of the mirrored table and the result of one beat
	function automatic rpc_result_t profile_step(input rpc_item_t b);
		rpc_result_t      r;
		int unsigned      idx;
		logic [SUM_W-1:0] dw;
		logic [SUM_W-1:0] du;
		logic [SUM_W-1:0] ds;
		r = '0;
		idx = 32'(b.region);
		if (idx >= REGIONS) begin
			r.status = ST_UNKNOWN;
			return r;
		end
		r.status = ST_OK;
		case (rpc_op_t'(b.op))
			OP_START: begin
				if (!enable_q) begin
					r.status = ST_DISABLED;
				end else if (!region_live[idx]) begin
					// first start, nesting limit not looked at
					region_live[idx]  = 1'b1;
					region_depth[idx] = DEPTH_W'(1);
					wall_start[idx]   = b.wall_time;
					user_start[idx]   = b.user_time;
					sys_start[idx]    = b.system_time;
					wall_acc[idx]     = '0;
					user_acc[idx]     = '0;
					sys_acc[idx]      = '0;
					close_count[idx]  = '0;
				end else if (region_depth[idx] >= b.max_nesting) begin
					r.status = ST_OVERFLOW;
				end else begin
					if (region_depth[idx] == '0) begin
						wall_start[idx] = b.wall_time;
						user_start[idx] = b.user_time;
						sys_start[idx]  = b.system_time;
					end
					region_depth[idx] = region_depth[idx] + DEPTH_W'(1);
				end
			end
			OP_END: begin
				if (!enable_q) begin
					r.status = ST_DISABLED;
				end else if (!region_live[idx]) begin
					r.status = ST_UNKNOWN;
				end else if (region_depth[idx] == '0) begin
					r.status = ST_NO_START;
				end else begin
					region_depth[idx] = region_depth[idx] - DEPTH_W'(1);
					close_count[idx]  = close_count[idx] + CNT_W'(1);
					if (region_depth[idx] == '0) begin
						dw = SUM_W'(b.wall_time) - SUM_W'(wall_start[idx]);
						du = SUM_W'(b.user_time) - SUM_W'(user_start[idx]);
						ds = SUM_W'(b.system_time) - SUM_W'(sys_start[idx]);
						wall_acc[idx] = wall_acc[idx] + dw;
						user_acc[idx] = user_acc[idx] + du;
						sys_acc[idx]  = sys_acc[idx] + ds;
						if (b.wall_time < wall_start[idx])
							r.status = ST_NEG_WALL;
					end
				end
			end
			OP_CLEAR: begin
				region_live[idx]  = 1'b1;
				region_depth[idx] = '0;
				wall_start[idx]   = '0;
				user_start[idx]   = '0;
				sys_start[idx]    = '0;
				wall_acc[idx]     = '0;
				user_acc[idx]     = '0;
				sys_acc[idx]      = '0;
				close_count[idx]  = '0;
			end
			default: begin
				if (!region_live[idx])
					r.status = ST_UNKNOWN;
			end
		endcase
		if (region_live[idx]) begin
			r.depth        = region_depth[idx];
			r.occurrences  = close_count[idx];
			r.wall_total   = wall_acc[idx];
			r.user_total   = user_acc[idx];
			r.system_total = sys_acc[idx];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rpc_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < REGIONS; i++) begin
				region_live[i]  = 1'b0;
				region_depth[i] = '0;
				wall_start[i]   = '0;
				user_start[i]   = '0;
				sys_start[i]    = '0;
				wall_acc[i]     = '0;
				user_acc[i]     = '0;
				sys_acc[i]      = '0;
				close_count[i]  = '0;
			end
			enable_q = 1'b0;
			pending_results.delete();
			fail_count = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result beat with nothing expected", $realtime);
				end else begin
					want = pending_results.pop_front();
					if (result !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: status exp %0d got %0d, depth exp %0d got %0d",
								$realtime, want.status, result.status, want.depth,
								result.depth);
							$display("    occ exp %0d got %0d", want.occurrences,
								result.occurrences);
							$display("    totals exp %h %h %h got %h %h %h",
								want.wall_total, want.user_total, want.system_total,
								result.wall_total, result.user_total, result.system_total);
						end
					end
				end
			end
			if (start && !busy)
				pending_results.push_back(profile_step(item));
			if (cfg_we)
				enable_q = cfg_data;
			mismatches  <= fail_count;
			outstanding <= pending_results.size();
		end
	end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the region profile counter table with directed beats, a deep
// nesting run and random start/end/clear/read traffic under both enable
// settings, with random idle bursts. The checker beside the block predicts
// and compares every result; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rpc_pkg::*;

	localparam int unsigned REGIONS = 64;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	rpc_item_t   item;
	logic        done;
	rpc_result_t result;
	logic        cfg_we;
	logic        cfg_data;
	int          mismatches;
	int          outstanding;

	// running timestamps of the traffic, moved forward beat by beat
	logic [TIME_W-1:0] wall_now;
	logic [TIME_W-1:0] user_now;
	logic [TIME_W-1:0] sys_now;
	// chance in percent of an idle burst after each beat
	int                idle_pct;

	region_profile_counter_table #(
		.REGIONS(REGIONS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	rpc_checker #(
		.REGIONS(REGIONS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5ms;
		$display("** region_profile_counter_table: FAILED **");
		$finish;
	end

	function automatic logic [TIME_W-1:0] rand_stamp();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[TIME_W-1:0];
	endfunction

	function automatic rpc_item_t mk(input rpc_op_t op, input int unsigned region,
		input int unsigned maxn, input logic [TIME_W-1:0] w, input logic [TIME_W-1:0] u,
		input logic [TIME_W-1:0] s);
		rpc_item_t b;
		b.op          = op;
		b.region      = REGION_W'(region);
		b.max_nesting = DEPTH_W'(maxn);
		b.wall_time   = w;
		b.user_time   = u;
		b.system_time = s;
		return b;
	endfunction

	// random beat: mostly start/end on a few hot regions with forward-moving
	// stamps, so nesting builds up and closes; now and then a stamp jumps
	// anywhere, which also gives negative elapsed wall time
	function automatic rpc_item_t random_beat();
		rpc_item_t   b;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 42)
			b.op = OP_START;
		else if (pick < 84)
			b.op = OP_END;
		else if (pick < 90)
			b.op = OP_CLEAR;
		else
			b.op = OP_READ;
		if ($urandom_range(9) < 7)
			b.region = REGION_W'($urandom_range(7));
		else
			b.region = REGION_W'($urandom_range(REGIONS - 1));
		pick = $urandom_range(99);
		if (pick < 80)
			b.max_nesting = DEPTH_W'($urandom_range(1, 6));
		else if (pick < 85)
			b.max_nesting = '0;
		else if (pick < 90)
			b.max_nesting = '1;
		else
			b.max_nesting = DEPTH_W'($urandom_range(255));
		wall_now = wall_now + TIME_W'($urandom_range(5000));
		user_now = user_now + TIME_W'($urandom_range(3000));
		sys_now  = sys_now + TIME_W'($urandom_range(1000));
		if ($urandom_range(19) == 0)
			wall_now = rand_stamp();
		if ($urandom_range(19) == 0)
			user_now = rand_stamp();
		if ($urandom_range(19) == 0)
			sys_now = rand_stamp();
		b.wall_time   = wall_now;
		b.user_time   = user_now;
		b.system_time = sys_now;
		return b;
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	// hold start until the beat is taken, then maybe idle for a burst;
	// start is left high so the next beat can follow on the next cycle
	task automatic issue(input rpc_item_t b);
		start <= 1'b1;
		item  <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// stop sending and wait until every expected result has come back
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_enable(input logic v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		rpc_item_t b;
		start    <= 1'b0;
		item     <= '0;
		cfg_we   <= 1'b0;
		cfg_data <= 1'b0;
		arst_n   <= 1'b0;
		idle_pct = 0;
		wall_now = rand_stamp();
		user_now = rand_stamp();
		sys_now  = rand_stamp();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed, enable still low from reset; the first beat also waits
		// out the sweep after reset through busy
		issue(mk(OP_READ, 0, 0, '0, '0, '0));
		issue(mk(OP_START, 5, 255, '1, '1, '1));
		issue(mk(OP_END, 5, 0, '1, '1, '1));
		issue(mk(OP_CLEAR, 63, 0, '0, '0, '0));
		issue(mk(OP_START, 63, 1, '1, '0, '1));
		drain();
		set_enable(1'b1);

		// directed, enabled, back to back, mostly on the same region
		issue(mk(OP_END, 7, 1, 40'd10, 40'd10, 40'd10));
		// first start with a zero limit still opens the entry
		issue(mk(OP_START, 7, 0, '1, '1, '1));
		issue(mk(OP_START, 7, 1, 40'd3, 40'd3, 40'd3));
		issue(mk(OP_START, 7, 255, 40'd4, 40'd4, 40'd4));
		issue(mk(OP_END, 7, 0, 40'd5, 40'd5, 40'd5));
		// closes the outer level with the wall stamp below the latched one
		issue(mk(OP_END, 7, 0, '0, '0, 40'd5));
		issue(mk(OP_END, 7, 0, 40'd6, 40'd6, 40'd6));
		issue(mk(OP_READ, 7, 0, '0, '0, '0));
		issue(mk(OP_START, 0, 1, '0, '0, '0));
		issue(mk(OP_END, 0, 255, '1, '1, '1));
		// valid entry at depth zero after a clear
		issue(mk(OP_START, 63, 1, 40'd100, 40'd200, 40'd300));
		issue(mk(OP_END, 63, 1, 40'd1100, 40'd1200, 40'd1300));
		issue(mk(OP_CLEAR, 0, 0, '1, '1, '1));
		issue(mk(OP_READ, 0, 0, '0, '0, '0));
		issue(mk(OP_READ, 33, 0, '1, '1, '1));
		drain();

		// deep nesting to the 8-bit limit and back out
		idle_pct = 15;
		issue(mk(OP_CLEAR, 42, 0, '0, '0, '0));
		for (int n = 0; n < 256; n++) begin
			b = random_beat();
			b.op = OP_START;
			b.region = 6'd42;
			b.max_nesting = '1;
			issue(b);
		end
		for (int n = 0; n < 256; n++) begin
			b = random_beat();
			b.op = OP_END;
			b.region = 6'd42;
			issue(b);
		end
		drain();

		// bulk random traffic, idling changed every 50 beats
		for (int n = 0; n < 700; n++) begin
			if (n % 50 == 0)
				idle_pct = pick_idle();
			issue(random_beat());
		end
		drain();

		// disabled: start and end only report, clear and read still act
		set_enable(1'b0);
		for (int n = 0; n < 100; n++) begin
			if (n % 50 == 0)
				idle_pct = pick_idle();
			issue(random_beat());
		end
		drain();

		// last stretch enabled again with no idling at all
		set_enable(1'b1);
		idle_pct = 0;
		for (int n = 0; n < 220; n++)
			issue(random_beat());
		drain();

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("** region_profile_counter_table: PASSED **");
		end else begin
			$display("** region_profile_counter_table: FAILED **");
		end
		$finish;
	end

endmodule
